// ----- rtl/core/bvsms_pkg.sv -----
// Shared types and constants for the battery voltage smoothing and mode select block.
// Used by every other file of the block; depends on nothing.
package bvsms_pkg;

   localparam int MV_BITS        = 16;
   localparam int ALPHA_REG_BITS = 17;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 17;

   typedef enum logic [1:0] {
      MODE_NONE        = 2'd0,
      MODE_OPERATIONAL = 2'd1,
      MODE_CRUISE      = 2'd2,
      MODE_POWER_SAFE  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_SMOOTHING_ALPHA     = 3'd0,
      CSR_RISE_OPERATIONAL_MV = 3'd1,
      CSR_RISE_CRUISE_MV      = 3'd2,
      CSR_FALL_OPERATIONAL_MV = 3'd3,
      CSR_FALL_CRUISE_MV      = 3'd4
   } csr_index_type;

   localparam logic [ALPHA_REG_BITS-1:0] ALPHA_RESET            = 17'd32768;
   localparam logic [MV_BITS-1:0]        RISE_OPERATIONAL_RESET = 16'd7500;
   localparam logic [MV_BITS-1:0]        RISE_CRUISE_RESET      = 16'd7200;
   localparam logic [MV_BITS-1:0]        FALL_OPERATIONAL_RESET = 16'd7100;
   localparam logic [MV_BITS-1:0]        FALL_CRUISE_RESET      = 16'd6500;

   typedef struct packed {
      logic [ALPHA_REG_BITS-1:0] smoothing_alpha;
      logic [MV_BITS-1:0]        rise_operational_mv;
      logic [MV_BITS-1:0]        rise_cruise_mv;
      logic [MV_BITS-1:0]        fall_operational_mv;
      logic [MV_BITS-1:0]        fall_cruise_mv;
   } cfg_type;

   typedef struct packed {
      mode_type           mode_command;
      logic [MV_BITS-1:0] smoothed_mv;
   } result_type;

endpackage

// ----- rtl/core/bvsms_if.sv -----
// Valid/ready channel interfaces for the sample and result beats.
// Depends on bvsms_pkg for the field widths.
interface bvsms_req_if;
   logic                         valid;
   logic                         ready;
   logic [bvsms_pkg::MV_BITS-1:0] battery_mv;

   modport source (output valid, output battery_mv, input ready);
   modport sink (input valid, input battery_mv, output ready);
endinterface

interface bvsms_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   mode_command;
   logic [bvsms_pkg::MV_BITS-1:0] smoothed_mv;

   modport source (output valid, output mode_command, output smoothed_mv, input ready);
   modport sink (input valid, input mode_command, input smoothed_mv, output ready);
endinterface

// ----- rtl/core/battery_voltage_smoothing_mode_select_core.sv -----
// Battery voltage smoother and mode selector. Each sample beat yields exactly one result beat
// through the sample register and then the result register; while the result side is ready a
// new sample is accepted in every cycle. The stored level is read and updated between the two
// registers, in logic that holds one multiply, one add and four compares.
// The first sample after reset only seeds the stored level and is returned with no command.
// Depends on bvsms_pkg, bvsms_if, bvsms_csr and bvsms_filter.
module battery_voltage_smoothing_mode_select_core #(
   parameter int VOLTAGE_BITS        = 16,
   parameter int ALPHA_FRACTION_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   bvsms_req_if.sink                           req_ch,
   bvsms_rsp_if.source                         rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [bvsms_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bvsms_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   bvsms_pkg::cfg_type             cfg;
   bvsms_pkg::result_type          result;
   logic                           in_valid_ff;
   logic                           in_valid_in;
   logic [bvsms_pkg::MV_BITS-1:0]  in_mv_ff;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   bvsms_pkg::result_type          rsp_data_ff;
   logic                           advance;
   logic                           step;
   logic                           accept;

   assign advance = !rsp_valid_ff || rsp_ch.ready;
   assign step    = in_valid_ff && advance;
   assign req_ch.ready = !reset && (!in_valid_ff || advance);
   assign accept  = req_ch.valid && req_ch.ready;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ch.ready);

   bvsms_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   bvsms_filter #(
      .VOLTAGE_BITS        (VOLTAGE_BITS),
      .ALPHA_FRACTION_BITS (ALPHA_FRACTION_BITS)
   ) u_filter (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .battery_mv (in_mv_ff),
      .cfg        (cfg),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_mv_ff <= req_ch.battery_mv;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.mode_command = 2'(rsp_data_ff.mode_command);
   assign rsp_ch.smoothed_mv  = rsp_data_ff.smoothed_mv;

endmodule

// ----- rtl/core/bvsms_csr.sv -----
// Configuration register file: smoothing factor and the four hysteresis thresholds.
// Depends on bvsms_pkg.
module bvsms_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [bvsms_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bvsms_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output bvsms_pkg::cfg_type                  cfg
);

   bvsms_pkg::cfg_type cfg_ff;
   bvsms_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (bvsms_pkg::csr_index_type'(csr_index))
            bvsms_pkg::CSR_SMOOTHING_ALPHA: begin
               cfg_in.smoothing_alpha = csr_wdata[bvsms_pkg::ALPHA_REG_BITS-1:0];
            end
            bvsms_pkg::CSR_RISE_OPERATIONAL_MV: begin
               cfg_in.rise_operational_mv = csr_wdata[bvsms_pkg::MV_BITS-1:0];
            end
            bvsms_pkg::CSR_RISE_CRUISE_MV: begin
               cfg_in.rise_cruise_mv = csr_wdata[bvsms_pkg::MV_BITS-1:0];
            end
            bvsms_pkg::CSR_FALL_OPERATIONAL_MV: begin
               cfg_in.fall_operational_mv = csr_wdata[bvsms_pkg::MV_BITS-1:0];
            end
            bvsms_pkg::CSR_FALL_CRUISE_MV: begin
               cfg_in.fall_cruise_mv = csr_wdata[bvsms_pkg::MV_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.smoothing_alpha     <= bvsms_pkg::ALPHA_RESET;
         cfg_ff.rise_operational_mv <= bvsms_pkg::RISE_OPERATIONAL_RESET;
         cfg_ff.rise_cruise_mv      <= bvsms_pkg::RISE_CRUISE_RESET;
         cfg_ff.fall_operational_mv <= bvsms_pkg::FALL_OPERATIONAL_RESET;
         cfg_ff.fall_cruise_mv      <= bvsms_pkg::FALL_CRUISE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/bvsms_filter.sv -----
// Exponential smoother with the stored level, seed flag and hysteresis mode selection.
// Depends on bvsms_pkg; the result is combinational and is registered by the caller.
module bvsms_filter #(
   parameter int VOLTAGE_BITS        = 16,
   parameter int ALPHA_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic [bvsms_pkg::MV_BITS-1:0] battery_mv,
   input  bvsms_pkg::cfg_type            cfg,
   output bvsms_pkg::result_type         result
);

   localparam int VB   = VOLTAGE_BITS;
   localparam int AFB  = ALPHA_FRACTION_BITS;
   localparam int AW   = AFB + 1;
   localparam int CMPW = (AW > bvsms_pkg::ALPHA_REG_BITS) ? AW : bvsms_pkg::ALPHA_REG_BITS;
   localparam int PW   = VB + AFB + 3;
   localparam int SW   = VB + AFB;
   localparam int TW   = ((VB > bvsms_pkg::MV_BITS) ? VB : bvsms_pkg::MV_BITS) + AFB;

   logic [VB-1:0]        level_ff;
   logic [VB-1:0]        level_in;
   logic                 seeded_ff;
   logic [VB-1:0]        sample;
   logic [CMPW-1:0]      alpha_ext;
   logic [CMPW-1:0]      alpha_one;
   logic [CMPW-1:0]      alpha_sat;
   logic [AW-1:0]        alpha_q;
   logic signed [VB:0]   diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] acc;
   logic [SW-1:0]        smoothed;
   logic                 falling;
   logic [TW-1:0]        smoothed_c;
   logic [TW-1:0]        rise_op_c;
   logic [TW-1:0]        rise_cr_c;
   logic [TW-1:0]        fall_op_c;
   logic [TW-1:0]        fall_cr_c;
   bvsms_pkg::mode_type  mode_sel;

   assign sample    = VB'(battery_mv);
   assign alpha_ext = CMPW'(cfg.smoothing_alpha);
   assign alpha_one = CMPW'(1) << AFB;
   assign alpha_sat = (alpha_ext > alpha_one) ? alpha_one : alpha_ext;
   assign alpha_q   = AW'(alpha_sat);

   assign diff     = $signed({1'b0, sample}) - $signed({1'b0, level_ff});
   assign prod     = $signed({1'b0, alpha_q}) * diff;
   assign acc      = $signed({3'b000, level_ff, {AFB{1'b0}}}) + prod;
   assign smoothed = acc[SW-1:0];
   assign falling  = prod[PW-1];

   assign smoothed_c = TW'(smoothed);
   assign rise_op_c  = TW'({cfg.rise_operational_mv, {AFB{1'b0}}});
   assign rise_cr_c  = TW'({cfg.rise_cruise_mv, {AFB{1'b0}}});
   assign fall_op_c  = TW'({cfg.fall_operational_mv, {AFB{1'b0}}});
   assign fall_cr_c  = TW'({cfg.fall_cruise_mv, {AFB{1'b0}}});

   always_comb begin
      mode_sel = bvsms_pkg::MODE_NONE;
      if (!falling) begin
         if (smoothed_c >= rise_op_c) begin
            mode_sel = bvsms_pkg::MODE_OPERATIONAL;
         end else if (smoothed_c >= rise_cr_c) begin
            mode_sel = bvsms_pkg::MODE_CRUISE;
         end
      end else begin
         if (smoothed_c <= fall_op_c) begin
            mode_sel = bvsms_pkg::MODE_CRUISE;
         end else if (smoothed_c <= fall_cr_c) begin
            mode_sel = bvsms_pkg::MODE_POWER_SAFE;
         end
      end
   end

   // The first sample after reset only seeds the stored level.
   always_comb begin
      if (seeded_ff) begin
         level_in            = smoothed[SW-1:AFB];
         result.mode_command = mode_sel;
      end else begin
         level_in            = sample;
         result.mode_command = bvsms_pkg::MODE_NONE;
      end
      result.smoothed_mv = bvsms_pkg::MV_BITS'(level_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         seeded_ff <= 1'b0;
      end else if (step) begin
         level_ff  <= level_in;
         seeded_ff <= 1'b1;
      end
   end

endmodule

// ----- rtl/core/bvsms_checker.sv -----
// Port-level checks on the smoothing core, attached to the top level by the bind below.
// Depends on bvsms_pkg and battery_voltage_smoothing_mode_select_core.
module bvsms_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_mode_command,
   input logic [bvsms_pkg::MV_BITS-1:0] rsp_smoothed_mv
);

   // A result beat held back by the sink keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode_command)
         && $stable(rsp_smoothed_mv))
      else $error("result beat changed while stalled");

   // No result beat is shown straight after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid straight after reset");

   // A new result beat follows an accepted sample beat, through the sample and result registers.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result beat without an accepted sample");

   // The sample side never stalls while the result side is taking beats.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("sample side stalled with a ready result side");

endmodule

bind battery_voltage_smoothing_mode_select_core bvsms_checker u_bvsms_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_mode_command (rsp_ch.mode_command),
   .rsp_smoothed_mv  (rsp_ch.smoothed_mv)
);

// ----- dv/tb_battery_voltage_smoothing_mode_select_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for battery_voltage_smoothing_mode_select_core: bursty sample beats,
// a stalling result side and a scoreboard that predicts each command and stored level.
// Depends on bvsms_pkg, the bvsms_if channel interfaces and the block itself.
module tb_battery_voltage_smoothing_mode_select_core;

   localparam int                                      ALPHA_FRACTION   = 16;
   localparam longint                                  ALPHA_UNITY      = 64'd65536;
   localparam logic [bvsms_pkg::ALPHA_REG_BITS-1:0]    ALPHA_ONE_REG    = 17'h10000;
   localparam logic [bvsms_pkg::ALPHA_REG_BITS-1:0]    ALPHA_MAX_REG    = 17'h1FFFF;
   localparam logic [bvsms_pkg::CSR_IDX_BITS-1:0]      CSR_UNUSED_INDEX = 3'd7;
   localparam int                                      STALL_LIMIT      = 2000;
   localparam int                                      RANDOM_PHASES    = 11;
   localparam int                                      PHASE_SAMPLES    = 95;

   class mode_command_board;
      bvsms_pkg::cfg_type            settings;
      logic [bvsms_pkg::MV_BITS-1:0] stored_level;
      bit                            level_seeded;
      bvsms_pkg::result_type         due_commands[$];
      int                            failures;
      int                            samples_taken;
      int                            commands_seen[4];

      function new();
         settings.smoothing_alpha     = bvsms_pkg::ALPHA_RESET;
         settings.rise_operational_mv = bvsms_pkg::RISE_OPERATIONAL_RESET;
         settings.rise_cruise_mv      = bvsms_pkg::RISE_CRUISE_RESET;
         settings.fall_operational_mv = bvsms_pkg::FALL_OPERATIONAL_RESET;
         settings.fall_cruise_mv      = bvsms_pkg::FALL_CRUISE_RESET;
         stored_level                 = '0;
         level_seeded                 = 1'b0;
         failures                     = 0;
         samples_taken                = 0;
         foreach (commands_seen[i]) commands_seen[i] = 0;
      endfunction

      function void write_reg(logic [bvsms_pkg::CSR_IDX_BITS-1:0] index,
                              logic [bvsms_pkg::CSR_DATA_BITS-1:0] data);
         case (index)
            bvsms_pkg::CSR_SMOOTHING_ALPHA:
               settings.smoothing_alpha     = data;
            bvsms_pkg::CSR_RISE_OPERATIONAL_MV:
               settings.rise_operational_mv = data[bvsms_pkg::MV_BITS-1:0];
            bvsms_pkg::CSR_RISE_CRUISE_MV:
               settings.rise_cruise_mv      = data[bvsms_pkg::MV_BITS-1:0];
            bvsms_pkg::CSR_FALL_OPERATIONAL_MV:
               settings.fall_operational_mv = data[bvsms_pkg::MV_BITS-1:0];
            bvsms_pkg::CSR_FALL_CRUISE_MV:
               settings.fall_cruise_mv      = data[bvsms_pkg::MV_BITS-1:0];
            default: ;
         endcase
      endfunction

      function longint scaled(logic [bvsms_pkg::MV_BITS-1:0] mv);
         return longint'(mv) <<< ALPHA_FRACTION;
      endfunction

      function void note_sample(logic [bvsms_pkg::MV_BITS-1:0] mv);
         bvsms_pkg::result_type due;
         longint                gain;
         longint                step;
         longint                level_q;
         due.mode_command = bvsms_pkg::MODE_NONE;
         samples_taken++;
         if (!level_seeded) begin
            level_seeded = 1'b1;
            stored_level = mv;
         end else begin
            gain = (settings.smoothing_alpha > ALPHA_UNITY) ? ALPHA_UNITY
                                                            : longint'(settings.smoothing_alpha);
            step    = gain * (longint'(mv) - longint'(stored_level));
            level_q = (longint'(stored_level) <<< ALPHA_FRACTION) + step;
            if (step >= 0) begin
               if (level_q >= scaled(settings.rise_operational_mv))
                  due.mode_command = bvsms_pkg::MODE_OPERATIONAL;
               else if (level_q >= scaled(settings.rise_cruise_mv))
                  due.mode_command = bvsms_pkg::MODE_CRUISE;
            end else begin
               if (level_q <= scaled(settings.fall_operational_mv))
                  due.mode_command = bvsms_pkg::MODE_CRUISE;
               else if (level_q <= scaled(settings.fall_cruise_mv))
                  due.mode_command = bvsms_pkg::MODE_POWER_SAFE;
            end
            stored_level = level_q[ALPHA_FRACTION +: bvsms_pkg::MV_BITS];
         end
         due.smoothed_mv = stored_level;
         due_commands.push_back(due);
      endfunction

      function void check_result(logic [1:0] mode, logic [bvsms_pkg::MV_BITS-1:0] mv);
         bvsms_pkg::result_type due;
         if (due_commands.size() == 0) begin
            failures++;
            $display({"%0t: result beat with nothing expected, expected none, ",
                      "actual mode %0d level %0d"}, $time, mode, mv);
            return;
         end
         due = due_commands.pop_front();
         if (!$isunknown(mode)) commands_seen[mode]++;
         if (mode !== due.mode_command) begin
            failures++;
            $display("%0t: mode_command mismatch, expected %0d, actual %0d",
                     $time, due.mode_command, mode);
         end
         if (mv !== due.smoothed_mv) begin
            failures++;
            $display("%0t: smoothed_mv mismatch, expected %0d, actual %0d",
                     $time, due.smoothed_mv, mv);
         end
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_write_enable;
   logic [bvsms_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [bvsms_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   bvsms_req_if req_ch ();
   bvsms_rsp_if rsp_ch ();

   mode_command_board             board;
   logic [bvsms_pkg::MV_BITS-1:0] script[$];
   logic [15:0]                   rsp_pattern = 16'hFFFF;
   logic [3:0]                    rsp_tick    = 4'd0;
   int                            burst_max   = 4;
   int                            gap_max     = 3;
   int                            idle_cycles = 0;
   int                            settings_applied = 1;

   battery_voltage_smoothing_mode_select_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   always @(negedge clock) begin
      rsp_ch.ready <= rsp_pattern[rsp_tick];
      rsp_tick     <= rsp_tick + 4'd1;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) board.write_reg(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready) board.note_sample(req_ch.battery_mv);
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result(rsp_ch.mode_command, rsp_ch.smoothed_mv);
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat on either channel for %0d cycles", $time, idle_cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic logic [bvsms_pkg::MV_BITS-1:0] near(int centre, int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[bvsms_pkg::MV_BITS-1:0];
   endfunction

   function automatic logic [bvsms_pkg::MV_BITS-1:0] pick_sample(int centre);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) return 16'h0000;
      if (roll < 8) return 16'hFFFF;
      if (roll < 25) return 16'($urandom);
      return near(centre, 3000);
   endfunction

   task automatic write_csr(input logic [bvsms_pkg::CSR_IDX_BITS-1:0] index,
                            input logic [bvsms_pkg::CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_wdata        <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [bvsms_pkg::CSR_DATA_BITS-1:0] alpha,
                                 input logic [bvsms_pkg::CSR_DATA_BITS-1:0] rise_op,
                                 input logic [bvsms_pkg::CSR_DATA_BITS-1:0] rise_cr,
                                 input logic [bvsms_pkg::CSR_DATA_BITS-1:0] fall_op,
                                 input logic [bvsms_pkg::CSR_DATA_BITS-1:0] fall_cr,
                                 input bit                                  poke_unused);
      write_csr(bvsms_pkg::CSR_SMOOTHING_ALPHA, alpha);
      write_csr(bvsms_pkg::CSR_RISE_OPERATIONAL_MV, rise_op);
      write_csr(bvsms_pkg::CSR_RISE_CRUISE_MV, rise_cr);
      write_csr(bvsms_pkg::CSR_FALL_OPERATIONAL_MV, fall_op);
      write_csr(bvsms_pkg::CSR_FALL_CRUISE_MV, fall_cr);
      if (poke_unused) write_csr(CSR_UNUSED_INDEX, 17'h0ABCD);
      csr_write_enable <= 1'b0;
      settings_applied++;
   endtask

   task automatic play_script();
      int burst_left;
      burst_left = $urandom_range(1, burst_max);
      foreach (script[i]) begin
         req_ch.valid      <= 1'b1;
         req_ch.battery_mv <= script[i];
         do @(posedge clock); while (!req_ch.ready);
         @(negedge clock);
         burst_left--;
         if (i == script.size() - 1) begin
            req_ch.valid <= 1'b0;
         end else if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, gap_max)) @(negedge clock);
            burst_left = $urandom_range(1, burst_max);
         end
      end
      script.delete();
   endtask

   task automatic wait_for_drain();
      while (board.due_commands.size() != 0) @(posedge clock);
      repeat (3) @(negedge clock);
   endtask

   initial begin
      int                                  centre;
      logic [bvsms_pkg::CSR_DATA_BITS-1:0] alpha;
      logic [bvsms_pkg::CSR_DATA_BITS-1:0] levels[4];
      board             = new();
      reset             = 1'b1;
      req_ch.valid      = 1'b0;
      req_ch.battery_mv = '0;
      rsp_ch.ready      = 1'b0;
      csr_write_enable  = 1'b0;
      csr_index         = '0;
      csr_wdata         = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: the first beat only seeds the level, then swings to both rails.
      script = '{16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd4095, 16'd4095, 16'd15000,
                 16'd15000, 16'd15000, 16'd7000, 16'd7000, 16'd7000, 16'd7000};
      play_script();
      wait_for_drain();

      // Alpha above one saturates; thresholds deliberately out of their usual order.
      apply_settings(ALPHA_MAX_REG, 17'd1000, 17'd2000, 17'd3000, 17'd5000, 1'b1);
      rsp_pattern = 16'h9249;
      burst_max   = 3;
      script = '{16'd10000, 16'd4000, 16'd2000, 16'd1500, 16'd500, 16'd0, 16'hFFFF, 16'hFFFF};
      play_script();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_for_drain();
         centre = $urandom_range(0, 65535);
         case (p)
            0:       alpha = '0;
            1:       alpha = ALPHA_ONE_REG;
            2:       alpha = 17'd1;
            3:       alpha = 17'($urandom_range(65537, 131071));
            default: alpha = 17'($urandom_range(0, 65536));
         endcase
         foreach (levels[i]) begin
            if (p == 4)      levels[i] = 17'd0;
            else if (p == 5) levels[i] = 17'h0FFFF;
            else             levels[i] = {1'($urandom), near(centre, 1500)};
         end
         apply_settings(alpha, levels[0], levels[1], levels[2], levels[3], p == 6);
         burst_max   = (p % 4 == 1) ? 100000 : $urandom_range(1, 16);
         gap_max     = $urandom_range(1, 6);
         rsp_pattern = (p % 3 == 0) ? 16'hFFFF : (16'($urandom) | 16'h0101);
         repeat (PHASE_SAMPLES) script.push_back(pick_sample(centre));
         play_script();
      end

      while (board.due_commands.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      $display("Run covered %0d sample beats under %0d register settings, stalls on both sides.",
               board.samples_taken, settings_applied);
      $display("Commands returned: none %0d, operational %0d, cruise %0d, power safe %0d.",
               board.commands_seen[bvsms_pkg::MODE_NONE],
               board.commands_seen[bvsms_pkg::MODE_OPERATIONAL],
               board.commands_seen[bvsms_pkg::MODE_CRUISE],
               board.commands_seen[bvsms_pkg::MODE_POWER_SAFE]);
      if (board.failures == 0 && board.due_commands.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
